// ===== design/susid_pkg.sv =====
// ----------------------------------------------------------------------------
// susid_pkg
// Shared types and constants of the sorted unique set insert/delete unit.
// ----------------------------------------------------------------------------
package susid_pkg;

    localparam int DEPTH    = 16;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== design/susid_req_if.sv =====
// ----------------------------------------------------------------------------
// susid_req_if
// Request channel: operation kind and signed value.
// ----------------------------------------------------------------------------
interface susid_req_if
    import susid_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== design/susid_rsp_if.sv =====
// ----------------------------------------------------------------------------
// susid_rsp_if
// Response channel: status, element count and first element.
// ----------------------------------------------------------------------------
interface susid_rsp_if
    import susid_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  first_value;

    modport source (output valid, output status, output count, output first_value,
                    input ready);
    modport sink   (input valid, input status, input count, input first_value,
                    output ready);
endinterface

// ===== design/susid_cfg_if.sv =====
// ----------------------------------------------------------------------------
// susid_cfg_if
// Configuration write channel carrying the sort order bit.
// ----------------------------------------------------------------------------
interface susid_cfg_if;
    logic valid;
    logic ready;
    logic order_descending;

    modport source (output valid, output order_descending, input ready);
    modport sink   (input valid, input order_descending, output ready);
endinterface

// ===== design/susid_cell.sv =====
// ----------------------------------------------------------------------------
// susid_cell
// One slot of the sorted chain: compares its entry with the request value
// and shifts toward or away from its neighbors on insert or remove.
// ----------------------------------------------------------------------------
module susid_cell
    import susid_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               occupied,
    input  logic               order_descending,
    input  logic [VALUE_W-1:0] key,
    input  logic               prev_ahead,
    input  logic [VALUE_W-1:0] left_value,
    input  logic [VALUE_W-1:0] right_value,
    output logic [VALUE_W-1:0] value,
    output logic [VALUE_W-1:0] value_next,
    output logic               ahead,
    output logic               equal
);
    logic [VALUE_W-1:0] value_reg;
    logic               less;
    logic               greater;

    assign less    = $signed(value_reg) < $signed(key);
    assign greater = $signed(value_reg) > $signed(key);
    assign ahead   = occupied && (order_descending ? greater : less);
    assign equal   = occupied && (value_reg == key);
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert && !ahead)
        begin
            value_next = prev_ahead ? key : left_value;
        end
        else if (ctrl.remove && !ahead)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end
endmodule

// ===== design/sorted_unique_set_insert_delete_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_set_insert_delete_unit
// Ordered set of unique signed values held in a chain of compare-and-shift
// cells, with add and delete requests and one response per request.
//
// Channel  Direction  Payload
// req      in         kind, value
// rsp      out        status, count, first_value
// cfg      in         order_descending
//
// Each request is first captured into registers; then every cell compares
// against the captured value at once and the chain shifts by one place.
// A new request is taken only when no request is busy and no response
// waits, or the waiting response is taken in the same cycle.
// A stalled response holds; reset empties the set and selects ascending order.
// A configuration write that changes the order empties the set.
// ----------------------------------------------------------------------------
module sorted_unique_set_insert_delete_unit
    import susid_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    susid_req_if.sink   req,
    susid_rsp_if.source rsp,
    susid_cfg_if.sink   cfg
);
    logic               busy_reg;
    logic               kind_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               order_reg;
    logic               rsp_valid_reg;
    status_t            status_reg;
    status_t            status_next;
    logic [COUNT_W-1:0] rsp_count_reg;
    logic [VALUE_W-1:0] first_reg;

    logic [VALUE_W-1:0] cell_value      [DEPTH];
    logic [VALUE_W-1:0] cell_value_next [DEPTH];
    logic [DEPTH-1:0]   cell_ahead;
    logic [DEPTH-1:0]   cell_equal;
    cell_ctrl_t         ctrl;
    logic               found;
    logic               full;
    logic               req_fire;

    assign req.ready = !busy_reg && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign found = |cell_equal;
    assign full  = (count_reg == CNT_W'(DEPTH));

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            susid_cell u_cell (
                .clk              (clk),
                .ctrl             (ctrl),
                .occupied         (CNT_W'(i) < count_reg),
                .order_descending (order_reg),
                .key              (key_reg),
                .prev_ahead       ((i == 0) ? 1'b1 : cell_ahead[(i == 0) ? 0 : i - 1]),
                .left_value       (cell_value[(i == 0) ? 0 : i - 1]),
                .right_value      (cell_value[(i == DEPTH - 1) ? i : i + 1]),
                .value            (cell_value[i]),
                .value_next       (cell_value_next[i]),
                .ahead            (cell_ahead[i]),
                .equal            (cell_equal[i])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = ST_ABSENT;
        if (kind_reg == KIND_ADD)
        begin
            if (found)
            begin
                status_next = ST_PRESENT;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
                ctrl.insert = busy_reg;
                count_next  = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (found)
            begin
                status_next = ST_REMOVED;
                ctrl.remove = busy_reg;
                count_next  = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            order_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (busy_reg)
            begin
                busy_reg      <= 1'b0;
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (req_fire)
            begin
                busy_reg <= 1'b1;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.order_descending != order_reg)
                begin
                    count_reg <= '0;
                end
                order_reg <= cfg.order_descending;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req.kind;
            key_reg  <= req.value;
        end
        if (busy_reg)
        begin
            status_reg    <= status_next;
            rsp_count_reg <= COUNT_W'(count_next);
            first_reg     <= (count_next != '0) ? cell_value_next[0] : '0;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.count       = rsp_count_reg;
    assign rsp.first_value = first_reg;
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted unique set insert/delete unit. A short
// directed sequence covers the value extremes, duplicates, deletes of absent
// values, an empty set and a full set. Random phases then follow, each after
// a sort order write, with values drawn mostly from a small pool so that the
// set fills and drains. A scoreboard predicts each response from the accepted
// requests and compares every field. Both channels stall at random, with one
// calm stretch and one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import susid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t             status;
        logic [COUNT_W-1:0]  count;
        logic [VALUE_W-1:0]  first_value;
    } set_outcome_t;

    class set_scoreboard;
        logic [VALUE_W-1:0] held[DEPTH];
        int                 held_count;
        bit                 descending;
        set_outcome_t       awaited[$];
        int                 errors;

        function new();
            held_count = 0;
            descending = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void write_order(bit order_bit);
            if (order_bit != descending)
                held_count = 0;
            descending = order_bit;
        endfunction

        function bit ahead_of(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
            return descending ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
        endfunction

        function void note_request(logic kind, logic [VALUE_W-1:0] value);
            int           pos;
            bit           hit;
            set_outcome_t outcome;
            pos = 0;
            while (pos < held_count && ahead_of(held[pos], value))
                pos++;
            hit = (pos < held_count) && (held[pos] == value);
            if (kind == KIND_ADD)
            begin
                if (hit)
                    outcome.status = ST_PRESENT;
                else if (held_count >= DEPTH)
                    outcome.status = ST_FULL;
                else
                begin
                    for (int i = held_count; i > pos; i--)
                        held[i] = held[i - 1];
                    held[pos] = value;
                    held_count++;
                    outcome.status = ST_INSERTED;
                end
            end
            else
            begin
                if (hit)
                begin
                    for (int i = pos; i + 1 < held_count; i++)
                        held[i] = held[i + 1];
                    held_count--;
                    outcome.status = ST_REMOVED;
                end
                else
                    outcome.status = ST_ABSENT;
            end
            outcome.count       = COUNT_W'(held_count);
            outcome.first_value = (held_count > 0) ? held[0] : '0;
            awaited.push_back(outcome);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                                   logic [VALUE_W-1:0] first_value);
            set_outcome_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response: status %0d count %0d first %h",
                             status, count, first_value);
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status || count !== want.count ||
                first_value !== want.first_value)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected status %0d count %0d first %h, got %0d %0d %h",
                             want.status, want.count, want.first_value,
                             status, count, first_value);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    bit   hold_request;

    susid_req_if req();
    susid_rsp_if rsp();
    susid_cfg_if cfg();

    set_scoreboard sb = new();

    sorted_unique_set_insert_delete_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_result(rsp.status, rsp.count, rsp.first_value);
            if (cfg.valid && cfg.ready)
                sb.write_order(cfg.order_descending);
            if (req.valid && req.ready)
                sb.note_request(req.kind, req.value);
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
        end
    end

    task automatic push_request(input logic kind, input logic [VALUE_W-1:0] value);
        while (!calm && $urandom_range(99) < 37)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.kind  <= kind;
        req.value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_order(input bit order_bit);
        wait_drained();
        cfg.valid            <= 1'b1;
        cfg.order_descending <= order_bit;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic run_directed();
        push_request(KIND_DELETE, 32'd77);
        push_request(KIND_ADD, 32'h7fff_ffff);
        push_request(KIND_ADD, 32'h8000_0000);
        push_request(KIND_ADD, 32'h0000_0000);
        push_request(KIND_ADD, 32'hffff_ffff);
        push_request(KIND_ADD, 32'h7fff_ffff);
        push_request(KIND_DELETE, 32'd5);
        push_request(KIND_DELETE, 32'h8000_0000);
        for (int i = 1; i <= 13; i++)
            push_request(KIND_ADD, VALUE_W'(i * 1000 + 1 - 7000));
        push_request(KIND_ADD, 32'd12345);
        push_request(KIND_ADD, 32'h0000_0000);
    endtask

    task automatic run_random(input int n_items, input int calm_items);
        logic [VALUE_W-1:0] pool[24];
        logic [VALUE_W-1:0] value;
        int                 add_odds;
        logic               kind;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7fff_ffff;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 24; i++)
            pool[i] = (i < 12) ? VALUE_W'($urandom_range(40) - 20) : VALUE_W'($urandom);
        add_odds = 70;
        for (int n = 0; n < n_items; n++)
        begin
            calm = (n < calm_items);
            if (n % 48 == 47)
                add_odds = 100 - add_odds;
            kind  = ($urandom_range(99) < add_odds) ? KIND_ADD : KIND_DELETE;
            value = ($urandom_range(99) < 75) ? pool[$urandom_range(23)] : VALUE_W'($urandom);
            push_request(kind, value);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        calm                 = 1'b0;
        hold_request         = 1'b0;
        req.valid            = 1'b0;
        req.kind             = KIND_ADD;
        req.value            = '0;
        rsp.ready            = 1'b0;
        cfg.valid            = 1'b0;
        cfg.order_descending = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        write_order(1'b0);
        run_random(250, 0);
        write_order(1'b1);
        run_random(250, 150);
        write_order(1'b1);
        hold_request = 1'b1;
        run_random(250, 0);
        write_order(1'b0);
        run_random(250, 0);
        write_order(1'b1);
        run_random(250, 0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
